// ===== sv/spq_pkg.sv =====
// Package for the sorted minimum priority queue: widths, request and status
// codes, and the control bundle broadcast to every storage cell.
// No dependencies.
`default_nettype none

package spq_pkg;

  localparam int DataW        = 32;
  localparam int StatusW      = 2;
  localparam int CountOutW    = 5;
  localparam int DefaultDepth = 16;

  localparam logic REQ_ENQ = 1'b0;
  localparam logic REQ_DEQ = 1'b1;

  localparam logic [StatusW-1:0] ST_OK    = 2'd0;
  localparam logic [StatusW-1:0] ST_FULL  = 2'd1;
  localparam logic [StatusW-1:0] ST_EMPTY = 2'd2;

  // Broadcast to all cells in the cycle a transaction is taken.
  typedef struct packed {
    logic                    enq_en;
    logic                    deq_en;
    logic signed [DataW-1:0] value;
  } cell_ctrl_t;

endpackage

`default_nettype wire

// ===== sv/spq_ifs.sv =====
// Valid/ready channel interfaces for requests and results of the queue.
// Depends on spq_pkg.
`default_nettype none

interface spq_req_if;
  logic                            valid;
  logic                            ready;
  logic                            req_type;
  logic signed [spq_pkg::DataW-1:0] item_value;

  modport source (output valid, output req_type, output item_value, input ready);
  modport sink   (input valid, input req_type, input item_value, output ready);
endinterface

interface spq_rsp_if;
  logic                                valid;
  logic                                ready;
  logic signed [spq_pkg::DataW-1:0]     taken_value;
  logic        [spq_pkg::StatusW-1:0]   status;
  logic signed [spq_pkg::DataW-1:0]     head_value;
  logic        [spq_pkg::CountOutW-1:0] entry_count;

  modport source (output valid, output taken_value, output status, output head_value,
                  output entry_count, input ready);
  modport sink   (input valid, input taken_value, input status, input head_value,
                  input entry_count, output ready);
endinterface

`default_nettype wire

// ===== sv/spq_cell.sv =====
// One storage cell of the sorted chain: holds one entry, compares it with
// the incoming value and shifts towards either neighbour. Depends on spq_pkg.
`default_nettype none

module spq_cell #(
  parameter int Idx  = 0,
  parameter int CntW = 5
) (
  input  wire logic                             clk_i,
  input  wire spq_pkg::cell_ctrl_t              ctrl_i,
  input  wire logic [CntW-1:0]                  count_i,
  input  wire logic signed [spq_pkg::DataW-1:0] left_value_i,
  input  wire logic                             left_gt_i,
  input  wire logic signed [spq_pkg::DataW-1:0] right_value_i,
  output logic signed [spq_pkg::DataW-1:0]      value_o,
  output logic                                  gt_o
);
  import spq_pkg::*;

  logic signed [DataW-1:0] value_q, value_d;
  logic                    occupied;
  logic                    at_tail;

  assign occupied = CntW'(Idx) < count_i;
  assign at_tail  = CntW'(Idx) == count_i;
  // Entry is strictly larger than the incoming value: it must move right.
  assign gt_o     = occupied && (ctrl_i.value < value_q);
  assign value_o  = value_q;

  always_comb begin
    value_d = value_q;
    if (ctrl_i.enq_en) begin
      if (left_gt_i) begin
        value_d = left_value_i;
      end else if (gt_o || at_tail) begin
        value_d = ctrl_i.value;
      end
    end else if (ctrl_i.deq_en) begin
      value_d = right_value_i;
    end
  end

  always_ff @(posedge clk_i) begin
    value_q <= value_d;
  end

endmodule

`default_nettype wire

// ===== sv/sorted_min_priority_queue.sv =====
// Sorted minimum priority queue: a chain of DEPTH cells kept in ascending order.
// The result is registered in the cycle after the request is taken.
// Throughput: one request per cycle while results are taken; every cell compares
// and shifts in the same cycle, so the chain length does not add cycles.
// Reset (rst_ni low, asynchronous) empties the queue and drops any pending result;
// the entries themselves are not cleared. Depends on spq_pkg, spq_ifs.
`default_nettype none

module sorted_min_priority_queue #(
  parameter int DEPTH = spq_pkg::DefaultDepth
) (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  spq_req_if.sink    req_i,
  spq_rsp_if.source  rsp_o
);
  import spq_pkg::*;

  localparam int CntW = $clog2(DEPTH + 1);

  // Occupancy count; cells below it hold valid entries.
  logic [CntW-1:0] count_q, count_d;

  // Result register, parting the request side from the result side.
  logic                     rsp_valid_q;
  logic signed [DataW-1:0]  taken_q, taken_d;
  logic [StatusW-1:0]       status_q, status_d;
  logic signed [DataW-1:0]  head_q, head_d;

  logic                     accept;
  logic                     is_full;
  logic                     is_empty;
  cell_ctrl_t               ctrl;

  // Cell chain wiring.
  logic signed [DataW-1:0]  cell_value [DEPTH];
  logic                     cell_gt    [DEPTH];

  logic [CntW+CountOutW-1:0] count_ext;

  // Take a new transaction whenever the result slot is free or being drained.
  assign req_i.ready = !rsp_valid_q || rsp_o.ready;
  assign accept      = req_i.valid && req_i.ready;
  assign is_full     = count_q == CntW'(DEPTH);
  assign is_empty    = count_q == '0;

  assign ctrl.enq_en = accept && (req_i.req_type == REQ_ENQ) && !is_full;
  assign ctrl.deq_en = accept && (req_i.req_type == REQ_DEQ) && !is_empty;
  assign ctrl.value  = req_i.item_value;

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic signed [DataW-1:0] left_value;
    logic                    left_gt;
    logic signed [DataW-1:0] right_value;

    if (i == 0) begin : g_first
      assign left_value = '0;
      assign left_gt    = 1'b0;
    end else begin : g_inner_l
      assign left_value = cell_value[i-1];
      assign left_gt    = cell_gt[i-1];
    end

    if (i == DEPTH - 1) begin : g_last
      // Past the tail after a dequeue: content is never read.
      assign right_value = cell_value[i];
    end else begin : g_inner_r
      assign right_value = cell_value[i+1];
    end

    spq_cell #(
      .Idx  (i),
      .CntW (CntW)
    ) u_cell (
      .clk_i         (clk_i),
      .ctrl_i        (ctrl),
      .count_i       (count_q),
      .left_value_i  (left_value),
      .left_gt_i     (left_gt),
      .right_value_i (right_value),
      .value_o       (cell_value[i]),
      .gt_o          (cell_gt[i])
    );
  end

  // Work out the result and the new head alongside the shift.
  always_comb begin
    count_d  = count_q;
    taken_d  = '0;
    status_d = ST_OK;
    head_d   = is_empty ? '0 : cell_value[0];
    if (ctrl.enq_en) begin
      count_d = count_q + 1'b1;
      if (is_empty || cell_gt[0]) begin
        head_d = ctrl.value;
      end
    end else if (ctrl.deq_en) begin
      count_d = count_q - 1'b1;
      taken_d = cell_value[0];
      head_d  = (count_q > CntW'(1)) ? cell_value[1] : '0;
    end else if (req_i.req_type == REQ_ENQ) begin
      status_d = ST_FULL;
    end else begin
      status_d = ST_EMPTY;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      rsp_valid_q <= 1'b0;
    end else begin
      if (accept) begin
        count_q     <= count_d;
        rsp_valid_q <= 1'b1;
      end else if (rsp_o.ready) begin
        rsp_valid_q <= 1'b0;
      end
    end
  end

  // Payload needs no reset; hold it until the next transaction.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      taken_q  <= taken_d;
      status_q <= status_d;
      head_q   <= head_d;
    end
  end

  // Report only the low bits of the count on the result channel.
  assign count_ext = {{CountOutW{1'b0}}, count_q};

  assign rsp_o.valid       = rsp_valid_q;
  assign rsp_o.taken_value = taken_q;
  assign rsp_o.status      = status_q;
  assign rsp_o.head_value  = head_q;
  assign rsp_o.entry_count = count_ext[CountOutW-1:0];

endmodule

`default_nettype wire

// ===== bench/testbench.sv =====
// Self-checking bench for sorted_min_priority_queue: random and directed
// enqueue/dequeue traffic over the valid/ready channels, checked against a
// sorted-list predictor. Depends on spq_pkg, spq_ifs and the queue RTL.
`default_nettype none

module testbench;
  import spq_pkg::*;

  localparam int DEPTH         = DefaultDepth;
  localparam int RANDOM_ITEMS  = 1825;
  localparam int HOLD_CYCLES   = 80;    // long receiver hold-off for back-pressure
  localparam int IDLE_LIMIT    = 2000;  // cycles without any transaction
  localparam int DRAIN_CYCLES  = 8;     // settle time after the last result

  // One result transaction, field for field as on the result channel.
  typedef struct packed {
    logic signed [DataW-1:0]     taken;
    logic        [StatusW-1:0]   status;
    logic signed [DataW-1:0]     head;
    logic        [CountOutW-1:0] count;
  } queue_result_t;

  // Holds a sorted copy of the queue contents and the results still owed.
  class queue_scoreboard;
    int unsigned             depth;
    logic signed [DataW-1:0] held[$];
    queue_result_t           owed[$];
    int unsigned             errors;

    function new(int unsigned depth_in);
      depth    = depth_in;
      errors   = 0;
    endfunction

    function int unsigned pending();
      return owed.size();
    endfunction

    // Apply an accepted request to the held copy and queue its result.
    function void note_request(logic kind, logic signed [DataW-1:0] value);
      queue_result_t r;
      int            pos;
      r.taken  = '0;
      r.status = ST_OK;
      if (kind == REQ_ENQ) begin
        if (held.size() >= depth) begin
          r.status = ST_FULL;
        end else begin
          // Insert after every entry not larger, so ties keep arrival order.
          pos = held.size();
          while (pos > 0 && value < held[pos-1]) pos--;
          held.insert(pos, value);
        end
      end else begin
        if (held.size() == 0) begin
          r.status = ST_EMPTY;
        end else begin
          r.taken = held.pop_front();
        end
      end
      r.head  = (held.size() > 0) ? held[0] : '0;
      r.count = CountOutW'(held.size());
      owed.push_back(r);
    endfunction

    function void flag(string what, longint want, longint got);
      errors++;
      $display("%0t: mismatch on %s: expected %0d, actual %0d", $time, what, want, got);
    endfunction

    function void check_result(queue_result_t got);
      queue_result_t want;
      if (owed.size() == 0) begin
        errors++;
        $display("%0t: unexpected result: expected none, actual taken %0d status %0d",
                 $time, got.taken, got.status);
        $display("%0t:   head %0d count %0d", $time, got.head, got.count);
        return;
      end
      want = owed.pop_front();
      if (got.taken  !== want.taken)  flag("taken_value", want.taken, got.taken);
      if (got.status !== want.status) flag("status", want.status, got.status);
      if (got.head   !== want.head)   flag("head_value", want.head, got.head);
      if (got.count  !== want.count)  flag("entry_count", want.count, got.count);
    endfunction
  endclass

  logic clk_i;
  logic rst_ni;

  spq_req_if req_if ();
  spq_rsp_if rsp_if ();

  sorted_min_priority_queue #(
    .DEPTH (DEPTH)
  ) i_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req_if),
    .rsp_o  (rsp_if)
  );

  queue_scoreboard sb = new(DEPTH);

  // Sender pacing: remaining items in the current burst, and a count of items
  // to be offered back to back while the receiver is held off.
  int burst_left;
  int steady_left;
  // Bumped by the stimulus for every long hold-off it wants from the receiver.
  int hold_off_reqs;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Sample both channels at the rising edge. Check the result before noting
  // the request: a request taken at this edge cannot have answered yet.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (rsp_if.valid && rsp_if.ready) begin
        sb.check_result(queue_result_t'{rsp_if.taken_value, rsp_if.status,
                                        rsp_if.head_value, rsp_if.entry_count});
      end
      if (req_if.valid && req_if.ready) begin
        sb.note_request(req_if.req_type, req_if.item_value);
      end
    end
  end

  // Watchdog: end the run if no transaction moves for too long.
  initial begin : watchdog
    int idle;
    idle = 0;
    forever begin
      @(posedge clk_i);
      if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready)) begin
        idle = 0;
      end else begin
        idle++;
      end
      if (idle >= IDLE_LIMIT) begin
        $display("%0t: no transaction for %0d cycles", $time, IDLE_LIMIT);
        $display("FAIL sorted_min_priority_queue");
        $finish;
      end
    end
  end

  // Receiver: stall on a pattern of its own that changes mode now and then,
  // including stretches of full readiness. On request, hold off for a long
  // stretch so the result slot stays full and back-pressures the request channel.
  initial begin : receiver
    int mode;
    int mode_left;
    int tick;
    int holds_done;
    mode         = 0;
    mode_left    = 0;
    tick         = 0;
    holds_done   = 0;
    rsp_if.ready = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (hold_off_reqs > holds_done) begin
        rsp_if.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk_i);
        holds_done++;
      end
      if (mode_left == 0) begin
        mode      = $urandom_range(0, 3);
        mode_left = $urandom_range(20, 200);
      end
      mode_left--;
      tick++;
      case (mode)
        0: rsp_if.ready <= 1'b1;
        1: rsp_if.ready <= ($urandom_range(0, 3) != 0);
        2: rsp_if.ready <= ($urandom_range(0, 3) == 0);
        default: rsp_if.ready <= ((tick % 5) < 2);
      endcase
    end
  end

  // Offer one request from the falling edge and hold it until it is taken.
  // A request following within a burst keeps valid high throughout.
  task automatic send_request(input logic kind, input logic signed [DataW-1:0] value);
    @(negedge clk_i);
    req_if.valid      <= 1'b1;
    req_if.req_type   <= kind;
    req_if.item_value <= value;
    do @(posedge clk_i); while (!req_if.ready);
  endtask

  // Send a request, then drop valid for a random gap at the end of a burst.
  task automatic issue_request(input logic kind, input logic signed [DataW-1:0] value);
    int gap;
    send_request(kind, value);
    if (steady_left > 0) begin
      steady_left--;
      return;
    end
    burst_left--;
    if (burst_left <= 0) begin
      burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(40, 120)
                                                : $urandom_range(1, 12);
      gap = $urandom_range(0, 6);
      repeat (gap) begin
        @(negedge clk_i);
        req_if.valid <= 1'b0;
        @(posedge clk_i);
      end
    end
  endtask

  // Mix of full-range values, a narrow band for plenty of ties, and the
  // extremes of the signed range.
  function automatic logic signed [DataW-1:0] pick_value();
    logic signed [DataW-1:0] v;
    case ($urandom_range(0, 9))
      0, 1, 2, 3, 4: v = $urandom;
      5, 6, 7:       v = $signed($urandom_range(0, 16)) - 8;
      8:             v = $urandom_range(0, 1) ? 32'sh7FFF_FFFF : 32'sh8000_0000;
      default:       v = $urandom_range(0, 1) ? 32'sh7FFF_FFFF - $urandom_range(0, 3)
                                              : 32'sh8000_0000 + $urandom_range(0, 3);
    endcase
    return v;
  endfunction

  initial begin : stimulus
    logic signed [DataW-1:0] fill_values[16];
    int sent;
    int phase_left;
    int enq_pct;
    logic kind;

    // Drive every input to a known value before reset is released.
    rst_ni            = 1'b0;
    req_if.valid      = 1'b0;
    req_if.req_type   = REQ_ENQ;
    req_if.item_value = '0;
    hold_off_reqs     = 0;
    burst_left        = 4;
    steady_left       = 0;

    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed part: dequeue from empty, fill with extremes, alternating bit
    // patterns and repeated values, enqueue while full, then drain a few and
    // add a value equal to ones still held.
    fill_values = '{32'sd0, -32'sd1, 32'sd1, 32'sh7FFF_FFFF, 32'sh8000_0000,
                    32'sd5, 32'sd5, 32'sd5, -32'sd5, 32'shAAAA_AAAA,
                    32'sh5555_5555, 32'sd100, -32'sd100, 32'sh7FFF_FFFE,
                    32'sh8000_0001, 32'sd2};
    issue_request(REQ_DEQ, 32'shFFFF_FFFF);
    foreach (fill_values[i]) issue_request(REQ_ENQ, fill_values[i]);
    issue_request(REQ_ENQ, 32'sd3);
    issue_request(REQ_ENQ, 32'sh8000_0000);
    repeat (4) issue_request(REQ_DEQ, '0);
    issue_request(REQ_ENQ, 32'sd5);

    // Random part: phases with a bias towards enqueue or dequeue, so the
    // count swings between empty and full many times over.
    sent       = 0;
    phase_left = 0;
    enq_pct    = 50;
    while (sent < RANDOM_ITEMS) begin
      if (phase_left == 0) begin
        phase_left = $urandom_range(10, 80);
        case ($urandom_range(0, 4))
          0: enq_pct = 90;
          1: enq_pct = 70;
          2: enq_pct = 50;
          3: enq_pct = 30;
          default: enq_pct = 10;
        endcase
      end
      phase_left--;
      // Hold the receiver off while requests keep coming back to back.
      if (sent == 600 || sent == 1300) begin
        hold_off_reqs++;
        steady_left = 60;
      end
      kind = ($urandom_range(0, 99) < enq_pct) ? REQ_ENQ : REQ_DEQ;
      issue_request(kind, pick_value());
      sent++;
    end
    @(negedge clk_i);
    req_if.valid <= 1'b0;

    // Wait for every owed result, then let the pipeline settle.
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("PASS sorted_min_priority_queue");
    end else begin
      $display("FAIL sorted_min_priority_queue");
    end
    $finish;
  end

endmodule

`default_nettype wire

// ===== sim.f =====
sv/spq_pkg.sv
sv/spq_ifs.sv
sv/spq_cell.sv
sv/sorted_min_priority_queue.sv
bench/testbench.sv
